@@ rtl/ptt_pkg.sv @@
package ptt_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int TIME_W = 32;
  localparam int ID_W = 8;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_PAUSE = 3'd1;
  localparam logic [2:0] OP_RESUME = 3'd2;
  localparam logic [2:0] OP_MODIFY = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;
  localparam logic [2:0] OP_TICK = 3'd6;
  localparam logic [2:0] OP_POLL = 3'd7;

  localparam logic [1:0] MODE_PAUSED = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ONESHOT = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  localparam logic CFG_MAX_INTERVAL = 1'b0;
  localparam logic CFG_DEFAULT_INTERVAL = 1'b1;

  localparam logic [TIME_W-1:0] MAX_INTERVAL_RESET = 32'd65535;
  localparam logic [TIME_W-1:0] DEFAULT_INTERVAL_RESET = 32'd50;

  typedef struct packed {
    logic [1:0] mode;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] ivl;
    logic [TIME_W-1:0] due;
  } entry_t;

  function automatic logic [1:0] norm_mode(input logic [2:0] sm);
    return (sm[1:0] == 2'd3) ? MODE_PERIODIC : sm[1:0];
  endfunction

endpackage

@@ rtl/periodic_task_timer_table.sv @@
// add and tick go straight to the result; lookups read one slot at a time through
// read and evaluate, up to TASK_SLOTS slots; remove and one-shot firing shift later
// slots down via shift read and write; one item at a time, next after result taken
// the entry table is one memory, with one read port and one write port
// reset: synchronous, clears counter, entry count, cursor and registers;
// table contents undefined until written, no clearing pass
module periodic_task_timer_table #(
  parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS,
  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
  localparam int CW = $clog2(TASK_SLOTS + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [7:0]  task_id,
  input  logic [31:0] interval,
  input  logic [2:0]  start_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic        found,
  output logic [1:0]  task_status,
  output logic        fire,
  output logic [7:0]  fired_task,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [31:0] max_interval, default_interval, tick_count;
  logic [CW-1:0] entry_count;
  logic [IW-1:0] scan_cursor;
  logic [2:0] op;
  logic [7:0] id;
  logic [31:0] ivl;
  logic [2:0] sm;
  logic [CW-1:0] idx;
  ptt_pkg::entry_t mem [TASK_SLOTS];
  ptt_pkg::entry_t rd;
  logic [31:0] sum;
  logic [31:0] diff;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_DONE);

  // shared adder for resume, modify and poll due times; subtractor for the wrap-safe due test
  always_comb begin
    sum = tick_count + ((op == ptt_pkg::OP_RESUME || op == ptt_pkg::OP_POLL) ? rd.ivl : ivl);
    diff = tick_count - rd.due;
  end

  always_ff @(posedge clk) begin
    rd <= mem[idx[IW-1:0]];
    if (state == S_IDLE && in_valid && operation == ptt_pkg::OP_ADD
        && entry_count < CW'(TASK_SLOTS)) begin
      mem[entry_count[IW-1:0]] <= '{mode: ptt_pkg::norm_mode(start_mode), id: task_id,
        ivl: ((interval == 32'd0 || interval > max_interval) ? default_interval : interval),
        due: (start_mode[2] ? tick_count : tick_count +
          ((interval == 32'd0 || interval > max_interval) ? default_interval : interval))};
    end else if (state == S_EVAL && op != ptt_pkg::OP_POLL && rd.id == id) begin
      case (op)
        ptt_pkg::OP_PAUSE: mem[idx[IW-1:0]] <= '{ptt_pkg::MODE_PAUSED, rd.id, rd.ivl, rd.due};
        ptt_pkg::OP_RESUME: mem[idx[IW-1:0]] <= '{ptt_pkg::MODE_PERIODIC, rd.id, rd.ivl, sum};
        ptt_pkg::OP_MODIFY: mem[idx[IW-1:0]] <= '{(sm[1:0] != 2'd0) ? ptt_pkg::norm_mode(sm)
          : rd.mode, rd.id, ivl, sum};
        default: ;
      endcase
    end else if (state == S_EVAL && op == ptt_pkg::OP_POLL && rd.mode != ptt_pkg::MODE_PAUSED
        && !diff[31] && rd.mode != ptt_pkg::MODE_ONESHOT) begin
      mem[idx[IW-1:0]] <= '{rd.mode, rd.id, rd.ivl, sum};
    end else if (state == S_SHIFT_WR) begin
      mem[idx[IW-1:0]] <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_interval <= ptt_pkg::MAX_INTERVAL_RESET;
      default_interval <= ptt_pkg::DEFAULT_INTERVAL_RESET;
      tick_count <= '0;
      entry_count <= '0;
      scan_cursor <= '0;
      idx <= '0;
      ok <= 1'b0;
      found <= 1'b0;
      task_status <= '0;
      fire <= 1'b0;
      fired_task <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ptt_pkg::CFG_MAX_INTERVAL) max_interval <= cfg_data;
        else default_interval <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation;
            id <= task_id;
            ivl <= interval;
            sm <= start_mode;
            ok <= 1'b0;
            found <= 1'b0;
            task_status <= '0;
            fire <= 1'b0;
            fired_task <= '0;
            idx <= '0;
            state <= S_READ;
            case (operation)
              ptt_pkg::OP_ADD: begin
                if (entry_count < CW'(TASK_SLOTS)) begin
                  entry_count <= entry_count + 1'b1;
                  ok <= 1'b1;
                end
                state <= S_DONE;
              end
              ptt_pkg::OP_TICK: begin
                tick_count <= tick_count + 32'd1;
                ok <= 1'b1;
                state <= S_DONE;
              end
              ptt_pkg::OP_POLL: begin
                if (entry_count == '0) begin
                  scan_cursor <= '0;
                  state <= S_DONE;
                end else begin
                  ok <= 1'b1;
                  if (CW'(scan_cursor) >= entry_count) begin
                    scan_cursor <= '0;
                    idx <= '0;
                  end else begin
                    idx <= CW'(scan_cursor);
                  end
                end
              end
              ptt_pkg::OP_QUERY, ptt_pkg::OP_MODIFY: begin
                if (operation == ptt_pkg::OP_QUERY) task_status <= ptt_pkg::STATUS_NOT_FOUND;
                if (entry_count == '0) state <= S_DONE;
              end
              default: begin
                if (entry_count == '0) state <= S_DONE;
                else ok <= 1'b1;
              end
            endcase
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (op == ptt_pkg::OP_POLL) begin
            if (rd.mode != ptt_pkg::MODE_PAUSED && !diff[31]) begin
              fire <= 1'b1;
              fired_task <= rd.id;
            end
            if (rd.mode == ptt_pkg::MODE_ONESHOT && !diff[31]) begin
              // cursor wraps against the count after the removal
              if (idx + 2'd2 >= entry_count) scan_cursor <= '0;
              else scan_cursor <= IW'(idx + 1'b1);
              if (idx + 1'b1 >= entry_count) begin
                entry_count <= entry_count - 1'b1;
                state <= S_DONE;
              end else begin
                idx <= idx + 1'b1;
                state <= S_SHIFT_RD;
              end
            end else begin
              if (idx + 1'b1 >= entry_count) scan_cursor <= '0;
              else scan_cursor <= IW'(idx + 1'b1);
              state <= S_DONE;
            end
          end else if (rd.id == id) begin
            found <= 1'b1;
            ok <= 1'b1;
            if (op == ptt_pkg::OP_QUERY) task_status <= rd.mode;
            if (op == ptt_pkg::OP_REMOVE) begin
              if (idx + 1'b1 >= entry_count) begin
                entry_count <= entry_count - 1'b1;
                state <= S_DONE;
              end else begin
                idx <= idx + 1'b1;
                state <= S_SHIFT_RD;
              end
            end else begin
              state <= S_DONE;
            end
          end else if (idx + 1'b1 >= entry_count) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_SHIFT_RD: begin
          idx <= idx - 1'b1;
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (idx + 2'd2 >= entry_count) begin
            entry_count <= entry_count - 1'b1;
            state <= S_DONE;
          end else begin
            idx <= idx + 2'd2;
            state <= S_SHIFT_RD;
          end
        end
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TASK_SLOTS)) else $error("entry count overflow");
  a_fire_poll: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire |-> op == ptt_pkg::OP_POLL && ok) else $error("fire outside poll");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> ok) else $error("found without ok");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid) else $error("repeated result");
`endif

endmodule
